[src/hrhp_pkg.sv]
// hrhp_pkg: types, phase codes, class codes and character constants for the
// response header parser; no dependencies, used by http_response_header_parser_top
package hrhp_pkg;

    // input beat: restart flag and raw reply byte
    typedef struct packed {
        logic       new_reply;
        logic [7:0] in_byte;
    } hrhp_in_t;

    // result beat: byte, its class, value end flag, status code and kind
    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] byte_class;
        logic       value_done;
        logic [9:0] status_code;
        logic [1:0] status_kind;
    } hrhp_out_t;

    // parse phase codes
    localparam logic [3:0] PH_SEEK        = 4'd0;
    localparam logic [3:0] PH_CODE_START  = 4'd1;
    localparam logic [3:0] PH_CODE_DIGITS = 4'd2;
    localparam logic [3:0] PH_STATUS_REST = 4'd3;
    localparam logic [3:0] PH_NAME        = 4'd4;
    localparam logic [3:0] PH_NAME_CR     = 4'd5;
    localparam logic [3:0] PH_PAD         = 4'd6;
    localparam logic [3:0] PH_VALUE       = 4'd7;
    localparam logic [3:0] PH_SKIP        = 4'd8;
    localparam logic [3:0] PH_BODY        = 4'd9;
    localparam logic [3:0] PH_MALFORMED   = 4'd10;

    // byte classes
    localparam logic [3:0] CLS_STATUS = 4'd0;
    localparam logic [3:0] CLS_NAME   = 4'd1;
    localparam logic [3:0] CLS_COLON  = 4'd2;
    localparam logic [3:0] CLS_PAD    = 4'd3;
    localparam logic [3:0] CLS_VALUE  = 4'd4;
    localparam logic [3:0] CLS_SKIP   = 4'd5;
    localparam logic [3:0] CLS_END    = 4'd6;
    localparam logic [3:0] CLS_BODY   = 4'd7;
    localparam logic [3:0] CLS_BAD    = 4'd8;

    // status kinds
    localparam logic [1:0] KIND_PENDING = 2'd0;
    localparam logic [1:0] KIND_OK      = 2'd1;
    localparam logic [1:0] KIND_NOMOD   = 2'd2;
    localparam logic [1:0] KIND_OTHER   = 2'd3;

    // status code constants
    localparam logic [9:0] CODE_RESET = 10'd404;
    localparam logic [9:0] CODE_MAX   = 10'd999;
    localparam logic [9:0] CODE_OK    = 10'd200;
    localparam logic [9:0] CODE_NOMOD = 10'd304;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

[src/http_response_header_parser_top.sv]
// http_response_header_parser_top: byte-serial classifier of a reply's status line
// and headers; depends on hrhp_pkg for beat types and codes
//
// Usage: the s_ channel carries one reply byte per beat, with new_reply set on
// the first byte of a reply to restart parsing. The m_ channel returns one beat
// per input beat: the byte, its class (status, name, colon, pad, value, skip,
// end of headers, body, malformed), a flag on the CR that ends a header value,
// the status code read so far and whether it is 200, 304, another code or still pending.
// Output: the result beat is registered, so a byte accepted at one edge shows on m_ after that edge.
// Throughput: one byte per cycle unless m_ready low holds the result; the parse state and
// the code accumulator are updated in the accepting cycle, so the next byte sees them
// at once. The critical path is the code multiply-by-ten, add and saturate at 999.
// Stall: a single result register holds the beat while m_ready is low; s_ready
// is high when that register is empty or being emptied in the same cycle.
// Reset: aresetn low clears the result valid, puts parsing at the search for
// the first space and the status code to 404.
module http_response_header_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrhp_pkg::hrhp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrhp_pkg::hrhp_out_t m_data
);
    import hrhp_pkg::*;

    logic [3:0] phase_reg, phase_next;
    logic [9:0] code_reg, code_next;
    logic       out_valid_reg, out_valid_next;
    hrhp_out_t  out_data_reg, out_data_next;

    logic       accept;
    logic [3:0] phase_cur;
    logic [9:0] code_cur;
    logic [7:0] b;
    logic       is_digit;
    logic [3:0] digit;
    logic [13:0] code_ext;
    logic [3:0] cls;
    logic       done;
    logic [1:0] kind;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // restart before the byte when a new reply begins
    assign phase_cur = s_data.new_reply ? PH_SEEK : phase_reg;
    assign code_cur  = s_data.new_reply ? CODE_RESET : code_reg;
    assign b         = s_data.in_byte;
    assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit     = 4'(b - CH_ZERO);

    // accumulate a decimal digit: acc * 10 + d, saturating
    assign code_ext = ({4'd0, code_cur} << 3) + ({4'd0, code_cur} << 1) + {10'd0, digit};

    // phase transition and byte class
    always_comb begin
        phase_next = phase_cur;
        code_next  = code_cur;
        cls        = CLS_BAD;
        done       = 1'b0;
        unique case (phase_cur)
            PH_SEEK: begin
                if (b == CH_SPACE) phase_next = PH_CODE_START;
                cls = CLS_STATUS;
            end
            PH_CODE_START: begin
                if (is_digit) begin
                    code_next  = {6'd0, digit};
                    phase_next = PH_CODE_DIGITS;
                    cls        = CLS_STATUS;
                end else if (b == CH_SPACE) begin
                    cls = CLS_STATUS;
                end else begin
                    phase_next = PH_MALFORMED;
                    cls        = CLS_BAD;
                end
            end
            PH_CODE_DIGITS: begin
                if (is_digit) begin
                    code_next = (code_ext > {4'd0, CODE_MAX}) ? CODE_MAX : code_ext[9:0];
                    cls       = CLS_STATUS;
                end else if (b == CH_SPACE) begin
                    phase_next = PH_STATUS_REST;
                    cls        = CLS_STATUS;
                end else begin
                    phase_next = PH_MALFORMED;
                    cls        = CLS_BAD;
                end
            end
            PH_STATUS_REST: begin
                if (b == CH_LF) phase_next = PH_NAME;
                cls = CLS_STATUS;
            end
            PH_NAME, PH_NAME_CR: begin
                if (phase_cur == PH_NAME_CR && b == CH_LF) begin
                    phase_next = PH_BODY;
                    cls        = CLS_END;
                end else if (b == CH_COLON) begin
                    phase_next = PH_PAD;
                    cls        = CLS_COLON;
                end else begin
                    phase_next = (b == CH_CR) ? PH_NAME_CR : PH_NAME;
                    cls        = CLS_NAME;
                end
            end
            PH_PAD, PH_VALUE: begin
                if (phase_cur == PH_PAD && b == CH_SPACE) begin
                    cls = CLS_PAD;
                end else if (b == CH_CR) begin
                    phase_next = PH_SKIP;
                    done       = 1'b1;
                    cls        = CLS_SKIP;
                end else begin
                    phase_next = PH_VALUE;
                    cls        = CLS_VALUE;
                end
            end
            PH_SKIP: begin
                if (b == CH_LF) phase_next = PH_NAME;
                cls = CLS_SKIP;
            end
            PH_BODY: begin
                cls = CLS_BODY;
            end
            default: begin
                phase_next = PH_MALFORMED;
                cls        = CLS_BAD;
            end
        endcase
    end

    // status kind from the phase and code after this byte
    always_comb begin
        priority if (phase_next <= PH_CODE_DIGITS || phase_next >= PH_MALFORMED) begin
            kind = KIND_PENDING;
        end else if (code_next == CODE_OK) begin
            kind = KIND_OK;
        end else if (code_next == CODE_NOMOD) begin
            kind = KIND_NOMOD;
        end else begin
            kind = KIND_OTHER;
        end
    end

    // result beat and valid
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept) begin
            out_valid_next            = 1'b1;
            out_data_next.out_byte    = b;
            out_data_next.byte_class  = cls;
            out_data_next.value_done  = done;
            out_data_next.status_code = code_next;
            out_data_next.status_kind = kind;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEEK;
            code_reg      <= CODE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                phase_reg <= phase_next;
                code_reg  <= code_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule
